// ===== rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and codes for the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 12;
  localparam int FILT_W = 3;

  // row filter codes; FILT_BAD marks a type byte above Paeth
  localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
  localparam logic [FILT_W-1:0] FILT_BAD   = 3'd5;

  // per-sample control passed from front to back
  typedef struct packed {
    logic [FILT_W-1:0] filter;
    logic              first_row;
    logic              row_start;
    logic              last;
  } psu_ctrl_t;

endpackage

// ===== rtl/psu_in_if.sv =====
// ----------------------------------------------------------------------------
// psu_in_if
// Filtered byte stream channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;

  modport source (output valid, output filtered_byte, input ready);
  modport sink   (input valid, input filtered_byte, output ready);
endinterface

// ===== rtl/psu_out_if.sv =====
// ----------------------------------------------------------------------------
// psu_out_if
// Reconstructed pixel byte channel: valid/ready with byte and row flags.
// ----------------------------------------------------------------------------
interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                  output ready);
endinterface

// ===== rtl/png_scanline_unfilter_unit.sv =====
// A sample byte passes the queue, the back end's b stage register and the output
// register; a filter type byte gives no result. Throughput: one byte per cycle while
// the output is not stalled, set by the line store read and write ports and the Paeth stage in the back end.
// Reset (rst, synchronous): control and handshake state clear, width returns to 1;
// the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG RGBA8 scanline defilter: front tags bytes, queue, back rebuilds them.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit import psu_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int PIXEL_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  psu_in_if.sink           bytes_in,
  psu_out_if.source        pixels_out
);

  localparam int LINE_DEPTH = MAX_WIDTH * PIXEL_BYTES;
  localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CTRL_W     = $bits(psu_ctrl_t);
  localparam int QDW        = BYTE_W + COL_W + CTRL_W;

  logic [CFG_W-1:0]  line_width;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [BYTE_W-1:0] f_byte;
  logic [COL_W-1:0]  f_col;
  psu_ctrl_t         f_ctrl;
  logic [QDW-1:0]    q_out;
  logic [BYTE_W-1:0] h_byte;
  logic [COL_W-1:0]  h_col;
  psu_ctrl_t         h_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  psu_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .PIXEL_BYTES (PIXEL_BYTES),
    .COL_W       (COL_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .bytes_in   (bytes_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_byte     (f_byte),
    .q_col      (f_col),
    .q_ctrl     (f_ctrl)
  );

  psu_queue #(
    .DW (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_byte, f_col, f_ctrl}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign {h_byte, h_col, h_ctrl} = q_out;

  psu_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .PIXEL_BYTES (PIXEL_BYTES),
    .COL_W       (COL_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_byte     (h_byte),
    .q_col      (h_col),
    .q_ctrl     (h_ctrl),
    .q_pop      (q_pop),
    .pixels_out (pixels_out)
  );

endmodule

// ===== rtl/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Takes stream bytes, picks off filter type bytes and tags each sample
// with its line store column and row control for the back end.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int PIXEL_BYTES = 4,
  parameter int COL_W       = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  line_width,
  psu_in_if.sink            bytes_in,
  input  logic              q_full,
  output logic              q_push,
  output logic [BYTE_W-1:0] q_byte,
  output logic [COL_W-1:0]  q_col,
  output psu_ctrl_t         q_ctrl
);

  localparam int LINE_DEPTH = MAX_WIDTH * PIXEL_BYTES;
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int CW         = (CFG_W > WW) ? CFG_W : WW;

  logic [COL_W-1:0]  column;
  logic [FILT_W-1:0] row_filter;
  logic              awaiting;
  logic              first_row;
  logic              row_start;

  logic              accept;
  logic [CW-1:0]     w_in;
  logic [CW-1:0]     w_clamp;
  logic [LEN_W-1:0]  row_len;
  logic [COL_W-1:0]  col_eff;
  logic              last;

  assign bytes_in.ready = !q_full;
  assign accept         = bytes_in.valid && !q_full;

  always_comb begin
    w_in = CW'(line_width);
    if (w_in == '0) begin
      w_clamp = CW'(1);
    end else if (w_in > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = w_in;
    end
    row_len = LEN_W'(w_clamp) * LEN_W'(PIXEL_BYTES);
    // a width cut mid-row ends the row at the new length
    if (LEN_W'(column) >= row_len) begin
      col_eff = COL_W'(row_len - LEN_W'(1));
    end else begin
      col_eff = column;
    end
    last = (LEN_W'(col_eff) + LEN_W'(1)) >= row_len;
  end

  assign q_push           = accept && !awaiting;
  assign q_byte           = bytes_in.filtered_byte;
  assign q_col            = col_eff;
  assign q_ctrl.filter    = row_filter;
  assign q_ctrl.first_row = first_row;
  assign q_ctrl.row_start = row_start;
  assign q_ctrl.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row_filter <= FILT_NONE;
      awaiting   <= 1'b1;
      first_row  <= 1'b1;
      row_start  <= 1'b1;
    end else if (accept) begin
      if (awaiting) begin
        row_filter <= (bytes_in.filtered_byte <= BYTE_W'(FILT_PAETH)) ?
                      FILT_W'(bytes_in.filtered_byte) : FILT_BAD;
        awaiting   <= 1'b0;
        column     <= '0;
        row_start  <= 1'b1;
      end else begin
        row_start <= 1'b0;
        if (last) begin
          column    <= '0;
          awaiting  <= 1'b1;
          first_row <= 1'b0;
        end else begin
          column <= col_eff + COL_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/psu_queue.sv =====
// ----------------------------------------------------------------------------
// psu_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module psu_queue #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  logic [DW-1:0] slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/psu_back.sv =====
// ----------------------------------------------------------------------------
// psu_back
// Line store read, filter reconstruction and output register.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int PIXEL_BYTES = 4,
  parameter int COL_W       = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  logic [BYTE_W-1:0] q_byte,
  input  logic [COL_W-1:0]  q_col,
  input  psu_ctrl_t         q_ctrl,
  output logic              q_pop,
  psu_out_if.source         pixels_out
);

  localparam int LINE_DEPTH = MAX_WIDTH * PIXEL_BYTES;
  localparam int LB         = BYTE_W * PIXEL_BYTES;

  logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic              b_valid;
  logic [BYTE_W-1:0] b_byte;
  logic [COL_W-1:0]  b_col;
  psu_ctrl_t         b_ctrl;
  logic              b_fwd;
  logic [BYTE_W-1:0] last_recon;

  logic [LB-1:0]     left_bytes;
  logic [LB-1:0]     upper_left_bytes;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_end;
  logic              out_bad;

  logic              b_fire;
  logic [LB-1:0]     left_eff;
  logic [LB-1:0]     ul_eff;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [9:0]        d_bc;
  logic [9:0]        d_ac;
  logic [9:0]        d_abc;
  logic [BYTE_W:0]   avg_sum;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] recon;
  logic              bad;

  assign b_fire = b_valid && (!out_valid || pixels_out.ready);
  assign q_pop  = !q_empty && (!b_valid || b_fire);

  assign pixels_out.valid      = out_valid;
  assign pixels_out.pixel_byte = out_byte;
  assign pixels_out.row_end    = out_end;
  assign pixels_out.bad_filter = out_bad;

  always_comb begin
    left_eff = b_ctrl.row_start ? '0 : left_bytes;
    ul_eff   = b_ctrl.row_start ? '0 : upper_left_bytes;
    a = left_eff[LB-1 -: BYTE_W];
    c = ul_eff[LB-1 -: BYTE_W];
    // same column written as it was read: take the byte just rebuilt
    if (b_ctrl.first_row) begin
      b = '0;
    end else if (b_fwd) begin
      b = last_recon;
    end else begin
      b = rdata;
    end

    d_bc  = {2'b00, b} - {2'b00, c};
    d_ac  = {2'b00, a} - {2'b00, c};
    d_abc = {2'b00, a} + {2'b00, b} - {1'b0, c, 1'b0};
    pa = d_bc[9]  ? -d_bc  : d_bc;
    pb = d_ac[9]  ? -d_ac  : d_ac;
    pc = d_abc[9] ? -d_abc : d_abc;
    avg_sum = {1'b0, a} + {1'b0, b};

    bad = 1'b0;
    case (b_ctrl.filter)
      FILT_NONE: pred = '0;
      FILT_SUB:  pred = a;
      FILT_UP:   pred = b;
      FILT_AVG:  pred = avg_sum[BYTE_W:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: begin
        pred = '0;
        bad  = 1'b1;
      end
    endcase
    recon = bad ? '0 : (b_byte + pred);
  end

  // line store: read-first, one write and one read a cycle
  always_ff @(posedge clk) begin
    if (b_fire) begin
      line_mem[b_col] <= recon;
    end
    if (q_pop) begin
      rdata <= line_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_byte <= q_byte;
      b_col  <= q_col;
      b_ctrl <= q_ctrl;
      b_fwd  <= b_fire && (b_col == q_col);
    end
    if (b_fire) begin
      last_recon       <= recon;
      left_bytes       <= LB'({left_eff, recon});
      upper_left_bytes <= LB'({ul_eff, b});
      out_byte         <= recon;
      out_end          <= b_ctrl.last;
      out_bad          <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (pixels_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the PNG scanline unfilter unit. A queue of stream bytes feeds
// a gapped valid/ready driver; each byte taken updates a local defilter model
// that queues the expected pixel bytes. A gapped monitor checks every result
// in order. It primes the line store with a first row wide enough for every
// later width, then runs directed rows and random phases of widths, filter
// types and partial rows.
// ----------------------------------------------------------------------------
module testbench import psu_pkg::*; ();

  localparam int MAX_W        = 2048;
  localparam int BPP          = 4;
  localparam int LINE_BYTES   = MAX_W * BPP;
  localparam int PRIME_W      = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_LONG    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PRINT_MAX    = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              row_end;
    logic              bad;
  } pixel_res_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  psu_in_if  bytes_if ();
  psu_out_if pixels_if ();

  png_scanline_unfilter_unit #(
    .MAX_WIDTH  (MAX_W),
    .PIXEL_BYTES(BPP)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .bytes_in   (bytes_if),
    .pixels_out (pixels_if)
  );

  // stimulus and expectations
  logic [BYTE_W-1:0] pending_bytes[$];
  pixel_res_t        expected_pixels[$];
  int                bytes_outstanding = 0;
  int                fail_count = 0;
  int                pixels_done = 0;
  bit                no_gaps = 1'b0;

  // defilter model state
  logic [BYTE_W-1:0]    line_store [LINE_BYTES];
  logic [8*BPP-1:0]     left_px = '0;
  logic [8*BPP-1:0]     upleft_px = '0;
  int unsigned          col = 0;
  logic [FILT_W-1:0]    row_filt = FILT_NONE;
  bit                   want_type = 1'b1;
  bit                   first_row = 1'b1;
  logic [CFG_W-1:0]     cfg_width = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else return $urandom_range(40, 8);
  endfunction

  function automatic logic [BYTE_W-1:0] paeth_choice(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
    int pa, pb, pc;
    pa = int'(b) - int'(c);
    pb = int'(a) - int'(c);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

  // one stream byte taken: update the model, queue a pixel for sample bytes
  task automatic rebuild_byte(input logic [BYTE_W-1:0] x);
    int unsigned       w, row_len;
    logic [BYTE_W-1:0] a, b, c, pred, recon;
    bit                bad, last;
    pixel_res_t        res;
    if (want_type) begin
      row_filt  = (x <= 8'd4) ? x[FILT_W-1:0] : FILT_BAD;
      want_type = 1'b0;
      col       = 0;
      left_px   = '0;
      upleft_px = '0;
    end else begin
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      row_len = w * BPP;
      // width shrunk mid-row: clamp to the last byte of the new row
      if (col >= row_len) col = row_len - 1;
      a = left_px[8*BPP-1 -: 8];
      b = first_row ? 8'd0 : line_store[col];
      c = upleft_px[8*BPP-1 -: 8];
      bad = 1'b0;
      case (row_filt)
        FILT_NONE:  pred = 8'd0;
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_choice(a, b, c);
        default: begin
          pred = 8'd0;
          bad  = 1'b1;
        end
      endcase
      recon = bad ? 8'd0 : x + pred;
      line_store[col] = recon;
      left_px   = {left_px[8*BPP-9:0], recon};
      upleft_px = {upleft_px[8*BPP-9:0], b};
      last = (col + 1 >= row_len);
      if (last) begin
        col       = 0;
        want_type = 1'b1;
        first_row = 1'b0;
      end else begin
        col = col + 1;
      end
      res.pixel   = recon;
      res.row_end = last;
      res.bad     = bad;
      expected_pixels.push_back(res);
    end
  endtask

  task automatic report(input string msg);
    if (fail_count < PRINT_MAX) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      bytes_if.valid         <= 1'b0;
      bytes_if.filtered_byte <= '0;
      send_gap = 0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        rebuild_byte(bytes_if.filtered_byte);
        bytes_outstanding--;
      end
      if (!bytes_if.valid || bytes_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          bytes_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          bytes_if.valid         <= 1'b1;
          bytes_if.filtered_byte <= pending_bytes.pop_front();
          send_gap = pick_gap();
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold = 0;
  always @(posedge clk) begin
    pixel_res_t got, want;
    if (rst) begin
      pixels_if.ready <= 1'b0;
      hold = 0;
    end else begin
      if (pixels_if.valid && pixels_if.ready) begin
        got.pixel   = pixels_if.pixel_byte;
        got.row_end = pixels_if.row_end;
        got.bad     = pixels_if.bad_filter;
        if (expected_pixels.size() == 0) begin
          report($sformatf("unexpected pixel %h end %b bad %b",
                           got.pixel, got.row_end, got.bad));
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
              got.bad !== want.bad)
            report($sformatf("pixel %0d: got %h end %b bad %b, want %h end %b bad %b",
                             pixels_done, got.pixel, got.row_end, got.bad,
                             want.pixel, want.row_end, want.bad));
        end
        pixels_done++;
        // long hold-off so the unit backs up and stalls its input
        if (pixels_done == 300 || pixels_done == 800) hold = HOLD_LONG;
        else hold = pick_gap();
      end
      if (hold > 0) begin
        hold--;
        pixels_if.ready <= 1'b0;
      end else begin
        pixels_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moved on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (pixels_if.valid && pixels_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    pending_bytes.push_back(value);
    bytes_outstanding++;
  endtask

  task automatic send_row(input logic [BYTE_W-1:0] kind, input int unsigned count);
    send_byte(kind);
    repeat (count) send_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    while (bytes_outstanding != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_width = value;
  endtask

  initial begin
    int unsigned       w, row_len, n, nrows, len, random_items;
    int                r;
    logic [BYTE_W-1:0] kind;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    bytes_if.valid         = 1'b0;
    bytes_if.filtered_byte = '0;
    pixels_if.ready        = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // over-range width acts as full width; the first row runs open to cover
    // every later width, then a cut to that width closes it on the next byte
    write_width(12'hFFF);
    no_gaps = 1'b1;
    send_row(8'(FILT_SUB), PRIME_W * BPP);
    write_width(CFG_W'(PRIME_W));
    send_byte(8'($urandom_range(255)));

    // directed rows, one pixel wide
    write_width(12'd0);
    no_gaps = 1'b0;
    send_byte(8'(FILT_NONE));
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'(FILT_UP));
    send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00); send_byte(8'h80);
    write_width(12'd1);
    send_byte(8'(FILT_AVG));
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'(FILT_PAETH));
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01);
    send_byte(8'd5);
    send_byte(8'hA5); send_byte(8'h5A); send_byte(8'hFF); send_byte(8'h00);
    // width shrinks mid-row: the next byte closes the row
    write_width(12'd2);
    send_byte(8'hFF);
    repeat (5) send_byte(8'($urandom_range(255)));
    write_width(12'd1);
    send_byte(8'($urandom_range(255)));

    // random phases
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 60) w = $urandom_range(8, 1);
      else if (r < 87) w = $urandom_range(32, 9);
      else if (r < 95) w = 0;
      else w = $urandom_range(PRIME_W, 33);
      write_width(w[CFG_W-1:0]);
      no_gaps = ($urandom_range(3) == 0);
      row_len = ((w == 0) ? 1 : w) * BPP;
      // finish a row left open by the previous phase
      if (!want_type) begin
        n = (col >= row_len) ? 1 : row_len - col;
        repeat (n) send_byte(8'($urandom_range(255)));
        random_items += n;
      end
      nrows = $urandom_range(6, 1);
      for (int i = 0; i < nrows; i++) begin
        kind = ($urandom_range(99) < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255, 5));
        len = row_len;
        if (i == nrows - 1 && $urandom_range(99) < 15)
          len = $urandom_range(row_len - 1, 0);
        send_row(kind, len);
        random_items += 1 + len;
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
